// ----- rtl/sfcf_pkg.sv -----
// Shared constants, opcodes and frame descriptor type of the SPI flash command framer.
package sfcf_pkg;

	localparam int PAGE_BYTES  = 256;
	localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int ADDR_BITS   = 24;

	localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;

	typedef enum logic [2:0] {
		KIND_PROGRAM   = 3'd0,
		KIND_ERASE_4K  = 3'd1,
		KIND_ERASE_32K = 3'd2,
		KIND_ERASE_64K = 3'd3,
		KIND_CHIP      = 3'd4,
		KIND_STATUS    = 3'd5,
		KIND_RESET     = 3'd6,
		KIND_NONE      = 3'd7
	} kind_t;

	// SPI NOR opcodes
	localparam logic [7:0] OP_WREN      = 8'h06;
	localparam logic [7:0] OP_PROGRAM   = 8'h02;
	localparam logic [7:0] OP_ERASE_4K  = 8'h20;
	localparam logic [7:0] OP_ERASE_32K = 8'h52;
	localparam logic [7:0] OP_ERASE_64K = 8'hD8;
	localparam logic [7:0] OP_CHIP      = 8'hC7;
	localparam logic [7:0] OP_RDSR1     = 8'h05;
	localparam logic [7:0] OP_RDSR2     = 8'h35;
	localparam logic [7:0] OP_RDSR3     = 8'h15;
	localparam logic [7:0] OP_WR_OFFSET = 8'h04;
	localparam logic [7:0] OP_RST_EN    = 8'h66;
	localparam logic [7:0] OP_RST       = 8'h99;

	localparam logic [1:0] SR_SEL_2 = 2'd2;
	localparam logic [1:0] SR_SEL_3 = 2'd3;

	// byte sequence shapes handed from front to back
	typedef enum logic [2:0] {
		SEQ_PROG_OPEN = 3'd0,
		SEQ_PROG_DATA = 3'd1,
		SEQ_ERASE     = 3'd2,
		SEQ_CHIP      = 3'd3,
		SEQ_STATUS    = 3'd4,
		SEQ_RESET     = 3'd5
	} seq_t;

	typedef struct packed {
		seq_t                 seq;
		logic [7:0]           cmd;
		logic [ADDR_BITS-1:0] addr;
		logic [7:0]           data;
		logic                 rel;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- rtl/spi_flash_command_framer.sv -----
// Top level of the SPI flash command framer: front end, descriptor queue and back end.
//
// Usage:
//   Requests enter on a queue-style port: an item is taken at a rising edge with push high
//   and full low. Each request (program byte, erase, chip erase, status write, reset)
//   becomes a run of SPI bytes carrying chip-select marks; kind 7 is taken and dropped.
//   Results leave on a queue-style port: while empty is low the oldest byte is on
//   mosi_byte/select_before/release_after/run_last, and it is taken with pop high.
// Path: a taken request is registered in the descriptor queue before its first byte reaches the result register.
// Throughput: the back end emits one byte per cycle unless pop stalls it; a request is 1 to 6
//   bytes (its byte count, set by the back end's byte counter); a four-entry descriptor queue
//   lets the front take new requests while the back is still expanding older ones.
// Stalls: with pop low the result byte holds; the back end stops, the queue fills and
//   full rises after four pending requests.
// Reset (arst_n low): queue and result register empty, no program frame open, next
//   program address zero.
module spi_flash_command_framer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [2:0]                     kind,
	input  logic [sfcf_pkg::ADDR_BITS-1:0] address,
	input  logic [7:0]                     data_byte,
	input  logic [1:0]                     status_select,
	input  logic                           write_begins,
	input  logic                           write_ends,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     mosi_byte,
	output logic                           select_before,
	output logic                           release_after,
	output logic                           run_last
);
	import sfcf_pkg::*;

	qstat_t qstat;
	desc_t  wr_desc;
	desc_t  rd_desc;
	logic   q_push;
	logic   q_pop;

	// full reflects the descriptor queue; every taken item costs at most one slot
	assign full = qstat.full;

	sfcf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.kind          (kind),
		.address       (address),
		.data_byte     (data_byte),
		.status_select (status_select),
		.write_begins  (write_begins),
		.write_ends    (write_ends),
		.qstat         (qstat),
		.q_push        (q_push),
		.q_desc        (wr_desc)
	);

	sfcf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_desc (wr_desc),
		.rd_en   (q_pop),
		.rd_desc (rd_desc),
		.qstat   (qstat)
	);

	sfcf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.q_desc        (rd_desc),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.mosi_byte     (mosi_byte),
		.select_before (select_before),
		.release_after (release_after),
		.run_last      (run_last)
	);

	// a byte sitting in the result register stays until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(mosi_byte) && $stable(run_last)))
		else $error("result byte lost while stalled");

endmodule

// ----- rtl/sfcf_front.sv -----
// Front end: accepts requests, tracks the open program frame and emits frame descriptors.
module sfcf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [2:0]                    kind,
	input  logic [sfcf_pkg::ADDR_BITS-1:0] address,
	input  logic [7:0]                    data_byte,
	input  logic [1:0]                    status_select,
	input  logic                          write_begins,
	input  logic                          write_ends,
	input  sfcf_pkg::qstat_t              qstat,
	output logic                          q_push,
	output sfcf_pkg::desc_t               q_desc
);
	import sfcf_pkg::*;

	logic                 frame_open_q;
	logic [ADDR_BITS-1:0] next_address_q;
	logic                 accept;
	logic                 prog;
	logic                 reopen;
	logic [ADDR_BITS-1:0] prog_addr;
	logic                 page_end;
	logic                 rel;
	kind_t                k;

	assign k      = kind_t'(kind);
	assign accept = push && !qstat.full;
	assign prog   = (k == KIND_PROGRAM);
	assign reopen = write_begins || !frame_open_q;
	assign prog_addr = write_begins ? address : next_address_q;
	assign page_end  = (&prog_addr[PAGE_BITS-1:0]) || (prog_addr == ADDR_TOP);
	assign rel       = write_ends || page_end;
	assign q_push    = accept && (k != KIND_NONE);

	always_comb begin
		q_desc      = '0;
		q_desc.data = data_byte;
		q_desc.addr = address;
		q_desc.rel  = rel;
		unique case (k)
			KIND_PROGRAM: begin
				q_desc.seq  = reopen ? SEQ_PROG_OPEN : SEQ_PROG_DATA;
				q_desc.addr = prog_addr;
				q_desc.cmd  = OP_PROGRAM;
			end
			KIND_ERASE_4K: begin
				q_desc.seq = SEQ_ERASE;
				q_desc.cmd = OP_ERASE_4K;
			end
			KIND_ERASE_32K: begin
				q_desc.seq = SEQ_ERASE;
				q_desc.cmd = OP_ERASE_32K;
			end
			KIND_ERASE_64K: begin
				q_desc.seq = SEQ_ERASE;
				q_desc.cmd = OP_ERASE_64K;
			end
			KIND_CHIP: begin
				q_desc.seq = SEQ_CHIP;
				q_desc.cmd = OP_CHIP;
			end
			KIND_STATUS: begin
				q_desc.seq = SEQ_STATUS;
				if (status_select == SR_SEL_2) begin
					q_desc.cmd = OP_RDSR2 - OP_WR_OFFSET;
				end else if (status_select == SR_SEL_3) begin
					q_desc.cmd = OP_RDSR3 - OP_WR_OFFSET;
				end else begin
					q_desc.cmd = OP_RDSR1 - OP_WR_OFFSET;
				end
			end
			KIND_RESET: begin
				q_desc.seq = SEQ_RESET;
				q_desc.cmd = OP_RST_EN;
			end
			default: begin
				q_desc.seq = SEQ_RESET;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q   <= 1'b0;
			next_address_q <= '0;
		end else if (q_push) begin
			if (prog) begin
				frame_open_q   <= !rel;
				next_address_q <= prog_addr + ADDR_BITS'(1);
			end else begin
				frame_open_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/sfcf_queue.sv -----
// Short descriptor queue between front and back.
module sfcf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  sfcf_pkg::desc_t  wr_desc,
	input  logic             rd_en,
	output sfcf_pkg::desc_t  rd_desc,
	output sfcf_pkg::qstat_t qstat
);
	import sfcf_pkg::*;

	desc_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign qstat.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_desc     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !qstat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !qstat.empty)
		else $error("queue read while empty");

endmodule

// ----- rtl/sfcf_back.sv -----
// Back end: expands each descriptor into SPI bytes, one per cycle unless pop stalls, into the result register.
module sfcf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sfcf_pkg::qstat_t qstat,
	input  sfcf_pkg::desc_t  q_desc,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       mosi_byte,
	output logic             select_before,
	output logic             release_after,
	output logic             run_last
);
	import sfcf_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic       load;
	logic       last;
	logic [2:0] len;
	logic [7:0] b;
	logic       sel;
	logic       rls;

	always_comb begin
		b   = OP_WREN;
		sel = 1'b0;
		rls = 1'b0;
		len = 3'd1;
		unique case (q_desc.seq)
			SEQ_PROG_OPEN, SEQ_ERASE: begin
				len = (q_desc.seq == SEQ_PROG_OPEN) ? 3'd6 : 3'd5;
				unique case (idx_q)
					3'd0: begin b = OP_WREN; sel = 1'b1; rls = 1'b1; end
					3'd1: begin b = q_desc.cmd; sel = 1'b1; end
					3'd2: b = q_desc.addr[23:16];
					3'd3: b = q_desc.addr[15:8];
					3'd4: begin
						b   = q_desc.addr[7:0];
						rls = (q_desc.seq == SEQ_ERASE);
					end
					default: begin b = q_desc.data; rls = q_desc.rel; end
				endcase
			end
			SEQ_PROG_DATA: begin
				b   = q_desc.data;
				rls = q_desc.rel;
			end
			SEQ_CHIP, SEQ_RESET: begin
				len = 3'd2;
				sel = 1'b1;
				rls = 1'b1;
				if (idx_q == 3'd0) begin
					b = (q_desc.seq == SEQ_RESET) ? OP_RST_EN : OP_WREN;
				end else begin
					b = (q_desc.seq == SEQ_RESET) ? OP_RST : q_desc.cmd;
				end
			end
			SEQ_STATUS: begin
				len = 3'd3;
				unique case (idx_q)
					3'd0: begin b = OP_WREN; sel = 1'b1; rls = 1'b1; end
					3'd1: begin b = q_desc.cmd; sel = 1'b1; end
					default: begin b = q_desc.data; rls = 1'b1; end
				endcase
			end
			default: begin
				b = OP_WREN;
			end
		endcase
	end

	assign last  = (idx_q == len - 3'd1);
	assign load  = !qstat.empty && (!out_valid_q || pop);
	assign q_pop = load && last;
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mosi_byte     <= b;
			select_before <= sel;
			release_after <= rls;
			run_last      <= last;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> (idx_q < len))
		else $error("byte index past end of frame sequence");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> (idx_q == 3'd0))
		else $error("byte index left mid-sequence with no descriptor");

endmodule

// ----- tb/tb_spi_flash_command_framer.sv -----
// Self-checking testbench for the SPI flash command framer: directed frames, then random traffic.
`timescale 1ns / 100ps

module tb_spi_flash_command_framer;

	import sfcf_pkg::*;

	// Run bounds. The limit leaves plenty of margin over the slowest legal run, with every
	// idle gap and every receiver stall at its longest.
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned RANDOM_ITEMS  = 168;
	localparam int unsigned MAX_IDLE      = 18;

	// One SPI byte as the framer should emit it.
	typedef struct packed {
		logic [7:0] mosi;
		logic       sel_before;
		logic       rel_after;
		logic       run_end;
	} spi_byte_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [2:0]           kind;
	logic [ADDR_BITS-1:0] address;
	logic [7:0]           data_byte;
	logic [1:0]           status_select;
	logic                 write_begins;
	logic                 write_ends;
	logic                 empty;
	logic                 pop;
	logic [7:0]           mosi_byte;
	logic                 select_before;
	logic                 release_after;
	logic                 run_last;

	// Predictor state: mirrors the framer's open program frame and its write pointer.
	bit                   frame_is_open;
	logic [ADDR_BITS-1:0] next_prog_addr;

	// Bytes still owed by the framer, oldest first, and the run built for one request.
	spi_byte_t            expected_bytes[$];
	spi_byte_t            request_bytes[$];

	// Idle shaping: a steady side never idles.
	bit                   send_steady;
	bit                   recv_steady;

	int unsigned          cycle_count;
	int unsigned          mismatches;
	int unsigned          bytes_checked;
	int unsigned          requests_sent;
	int unsigned          requests_dropped;
	int unsigned          program_bytes_sent;

	spi_flash_command_framer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.address       (address),
		.data_byte     (data_byte),
		.status_select (status_select),
		.write_begins  (write_begins),
		.write_ends    (write_ends),
		.empty         (empty),
		.pop           (pop),
		.mosi_byte     (mosi_byte),
		.select_before (select_before),
		.release_after (release_after),
		.run_last      (run_last)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hung handshake or a lost byte ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still owed",
				cycle_count, expected_bytes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned idle_cycles(bit steady);
		if (steady)
			return 0;
		// mostly short gaps, now and then a long one
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, MAX_IDLE);
		return $urandom_range(0, 2);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// ---------------------------------------------------------------- predictor

	task automatic emit(logic [7:0] b, logic sel, logic rel);
		spi_byte_t r;
		r.mosi       = b;
		r.sel_before = sel;
		r.rel_after  = rel;
		r.run_end    = 1'b0;
		request_bytes.push_back(r);
	endtask

	// 24-bit address, MSB first; only the final byte may release chip-select
	task automatic emit_address(logic [ADDR_BITS-1:0] a, logic rel_last);
		emit(a[23:16], 1'b0, 1'b0);
		emit(a[15:8], 1'b0, 1'b0);
		emit(a[7:0], 1'b0, rel_last);
	endtask

	task automatic predict_frames(kind_t k, logic [ADDR_BITS-1:0] a, logic [7:0] d,
			logic [1:0] s, bit begins, bit ends);
		logic [ADDR_BITS-1:0] at;
		bit                   closes;
		logic [7:0]           rd_op;
		spi_byte_t            tail;
		request_bytes.delete();
		// any request other than a program byte cuts off an open program frame
		if (k != KIND_PROGRAM && k != KIND_NONE)
			frame_is_open = 1'b0;
		case (k)
			KIND_PROGRAM: begin
				if (begins || !frame_is_open) begin
					// fresh write, or continuation after a page end / finished write
					at = begins ? a : next_prog_addr;
					emit(OP_WREN, 1'b1, 1'b1);
					emit(OP_PROGRAM, 1'b1, 1'b0);
					emit_address(at, 1'b0);
				end else begin
					at = next_prog_addr;
				end
				closes = ends || (at % PAGE_BYTES == PAGE_BYTES - 1) || (at == ADDR_TOP);
				emit(d, 1'b0, closes);
				next_prog_addr = at + 1'b1;
				frame_is_open  = !closes;
			end
			KIND_ERASE_4K, KIND_ERASE_32K, KIND_ERASE_64K: begin
				emit(OP_WREN, 1'b1, 1'b1);
				emit(k == KIND_ERASE_4K ? OP_ERASE_4K :
					k == KIND_ERASE_32K ? OP_ERASE_32K : OP_ERASE_64K, 1'b1, 1'b0);
				emit_address(a, 1'b1);
			end
			KIND_CHIP: begin
				emit(OP_WREN, 1'b1, 1'b1);
				emit(OP_CHIP, 1'b1, 1'b1);
			end
			KIND_STATUS: begin
				// select 0 falls back to status register 1
				rd_op = (s == SR_SEL_2) ? OP_RDSR2 : (s == SR_SEL_3) ? OP_RDSR3 : OP_RDSR1;
				emit(OP_WREN, 1'b1, 1'b1);
				emit(rd_op - OP_WR_OFFSET, 1'b1, 1'b0);
				emit(d, 1'b0, 1'b1);
			end
			KIND_RESET: begin
				emit(OP_RST_EN, 1'b1, 1'b1);
				emit(OP_RST, 1'b1, 1'b1);
			end
			default: ;
		endcase
		if (request_bytes.size() > 0) begin
			tail = request_bytes.pop_back();
			tail.run_end = 1'b1;
			request_bytes.push_back(tail);
		end
		foreach (request_bytes[i])
			expected_bytes.push_back(request_bytes[i]);
	endtask

	// ---------------------------------------------------------------- driving

	// Drives one item at the falling edge, holds it until taken, then predicts.
	// Returns at the falling edge after acceptance with push still high.
	task automatic send_item(kind_t k, logic [ADDR_BITS-1:0] a, logic [7:0] d,
			logic [1:0] s, bit begins, bit ends);
		int unsigned gap;
		gap = idle_cycles(send_steady);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind          = k;
		address       = a;
		data_byte     = d;
		status_select = s;
		write_begins  = begins;
		write_ends    = ends;
		push          = 1'b1;
		do
			@(posedge clk);
		while (full);
		predict_frames(k, a, d, s, begins, ends);
		if (k == KIND_NONE)
			requests_dropped++;
		else
			requests_sent++;
		if (k == KIND_PROGRAM)
			program_bytes_sent++;
		@(negedge clk);
	endtask

	// Sender holds off until every owed byte is out, then gives a dropped item
	// time to clear the pipeline before anything new goes in.
	task automatic wait_all_delivered();
		push = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic compare_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic check_spi_byte();
		spi_byte_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("byte 0x%02h arrived with nothing owed", mosi_byte));
			return;
		end
		want = expected_bytes.pop_front();
		compare_field("mosi_byte", mosi_byte, want.mosi);
		compare_field("select_before", select_before, want.sel_before);
		compare_field("release_after", release_after, want.rel_after);
		compare_field("run_last", run_last, want.run_end);
		bytes_checked++;
	endtask

	// Receiver: pop is set at the falling edge; a byte counts at a rising edge
	// with pop high and empty low. Stall length is redrawn after every byte.
	initial begin : receiver
		int unsigned hold;
		pop  = 1'b0;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			pop = (hold == 0);
			@(posedge clk);
			if (pop && !empty) begin
				check_spi_byte();
				hold = idle_cycles(recv_steady);
			end else if (hold > 0) begin
				hold--;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_erase_commands();
		send_item(KIND_ERASE_4K, 24'h000000, 8'h00, 2'd1, 1'b0, 1'b0);
		send_item(KIND_ERASE_32K, ADDR_TOP, 8'hFF, 2'd3, 1'b1, 1'b1);
		send_item(KIND_ERASE_64K, 24'(($urandom)), 8'($urandom), 2'd2, 1'b0, 1'b1);
		send_item(KIND_CHIP, ADDR_TOP, 8'hFF, 2'd0, 1'b1, 1'b0);
	endtask

	task automatic test_status_writes();
		// select 0 and 1 both land on status register 1
		send_item(KIND_STATUS, 24'h000000, 8'h00, 2'd0, 1'b0, 1'b0);
		send_item(KIND_STATUS, ADDR_TOP, 8'hFF, 2'd1, 1'b1, 1'b1);
		send_item(KIND_STATUS, 24'h5A5A5A, 8'hA5, SR_SEL_2, 1'b0, 1'b0);
		send_item(KIND_STATUS, 24'hA5A5A5, 8'h5A, SR_SEL_3, 1'b0, 1'b0);
	endtask

	task automatic test_device_reset();
		send_item(KIND_RESET, 24'h123456, 8'h77, 2'd2, 1'b1, 1'b0);
	endtask

	task automatic test_dropped_kind();
		// kind 7 yields nothing and leaves the program pointer alone
		send_item(KIND_NONE, 24'($urandom), 8'($urandom), 2'($urandom), 1'b1, 1'b1);
		send_item(KIND_NONE, 24'($urandom), 8'($urandom), 2'($urandom), 1'b0, 1'b0);
		wait_all_delivered();
	endtask

	task automatic test_program_pages();
		// page end closes the frame, next byte reopens at the following page
		send_item(KIND_PROGRAM, 24'h0000FE, 8'h11, 2'd0, 1'b1, 1'b0);
		send_item(KIND_PROGRAM, 24'hFFFFFF, 8'h22, 2'd0, 1'b0, 1'b0);
		send_item(KIND_PROGRAM, 24'h000000, 8'h33, 2'd0, 1'b0, 1'b0);
		send_item(KIND_PROGRAM, 24'h000000, 8'h44, 2'd0, 1'b0, 1'b1);
		// continuation after the write already ended
		send_item(KIND_PROGRAM, 24'hABCDEF, 8'h55, 2'd0, 1'b0, 1'b0);
		// new write while a frame is open: reselect at the top of the array
		send_item(KIND_PROGRAM, 24'hFFFFFE, 8'h00, 2'd0, 1'b1, 1'b0);
		send_item(KIND_PROGRAM, 24'h000000, 8'hFF, 2'd0, 1'b0, 1'b0);
		// pointer wrapped to zero
		send_item(KIND_PROGRAM, 24'hFFFFFF, 8'h66, 2'd0, 1'b0, 1'b1);
	endtask

	task automatic test_interrupted_write();
		send_item(KIND_PROGRAM, 24'h123456, 8'h99, 2'd0, 1'b1, 1'b0);
		send_item(KIND_ERASE_4K, 24'h654321, 8'h00, 2'd0, 1'b0, 1'b0);
		// reopens at 0x123457 since the erase kept the pointer
		send_item(KIND_PROGRAM, 24'h000000, 8'hAA, 2'd0, 1'b0, 1'b1);
		// one-byte write
		send_item(KIND_PROGRAM, 24'hABCDEF, 8'hBB, 2'd0, 1'b1, 1'b1);
	endtask

	// One item of anything, fields fully random, kind 7 included.
	task automatic send_noise_item();
		send_item(kind_t'($urandom_range(0, 7)), 24'($urandom), 8'($urandom),
			2'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// A well-formed write of random length, often placed across a page end or
	// the top of the array; now and then broken by a stray flag or a foreign request.
	task automatic send_random_write();
		int unsigned          len;
		logic [ADDR_BITS-1:0] start;
		bit                   begins;
		bit                   ends;
		len = $urandom_range(1, 12);
		case ($urandom_range(0, 3))
			0: start = (24'($urandom) & ~24'(PAGE_BYTES - 1)) + 24'(PAGE_BYTES - 1)
				- 24'($urandom_range(0, len));
			1: start = ADDR_TOP - 24'($urandom_range(0, len));
			default: start = 24'($urandom);
		endcase
		for (int unsigned i = 0; i < len; i++) begin
			begins = (i == 0);
			ends   = (i == len - 1);
			if ($urandom_range(0, 15) == 0)
				begins = !begins;
			if ($urandom_range(0, 15) == 0)
				ends = !ends;
			if ($urandom_range(0, 15) == 0)
				send_noise_item();
			send_item(KIND_PROGRAM, begins ? start : 24'($urandom), 8'($urandom),
				2'($urandom), begins, ends);
		end
	endtask

	task automatic test_random_traffic();
		int unsigned goal;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_steady = 1'b0; recv_steady = 1'b0; end
				1: begin send_steady = 1'b1; recv_steady = 1'b1; end
				2: begin send_steady = 1'b1; recv_steady = 1'b0; end
				default: begin send_steady = 1'b0; recv_steady = 1'b1; end
			endcase
			goal = requests_sent + RANDOM_ITEMS / 4;
			while (requests_sent < goal) begin
				if ($urandom_range(0, 9) < 6)
					send_random_write();
				else
					send_noise_item();
			end
			// full drain between the middle phases
			if (phase == 1)
				wait_all_delivered();
		end
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : main
		arst_n         = 1'b0;
		push           = 1'b0;
		kind           = KIND_NONE;
		address        = '0;
		data_byte      = '0;
		status_select  = '0;
		write_begins   = 1'b0;
		write_ends     = 1'b0;
		frame_is_open  = 1'b0;
		next_prog_addr = '0;
		send_steady    = 1'b0;
		recv_steady    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_erase_commands();
		test_status_writes();
		test_device_reset();
		test_dropped_kind();
		test_program_pages();
		test_interrupted_write();
		test_random_traffic();

		wait_all_delivered();
		$display("Sent %0d requests (%0d program bytes) plus %0d dropped items;",
			requests_sent, program_bytes_sent, requests_dropped);
		$display("checked %0d SPI bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
